// File: rtl/afr_pkg.sv
package afr_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] RESET_FRAME_TYPE = 8'h90;
  localparam logic [7:0] CSUM_BASE = 8'hFF;
  localparam int MAX_FRAME_DATA_DEFAULT = 64;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CSUM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DISCARD = 2'd0,
    KIND_LEN     = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  position;
    logic [7:0]  data;
    logic        good;
    logic        overflow;
  } result_t;

endpackage

// File: rtl/api_frame_receiver_core.sv
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  rx_byte
// out       source     out_valid / out_stall out_kind, data_position, data_byte,
//                                           frame_good, frame_overflow
// cfg       sink       cfg_valid / cfg_ready cfg_data (accepted frame type)
//
// one byte per clock while in_stall is low, one result per byte, registered to out_valid
// parse state updates in the accepting cycle, result lands in the output register
// a stalled output keeps taking one more beat into the skid register
// in_stall rises only while the skid register is full
// rst is synchronous: hunting for start byte, frame type back to 0x90
module api_frame_receiver_core #(
  parameter int MAX_FRAME_DATA = afr_pkg::MAX_FRAME_DATA_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // received bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // parse results
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [5:0] data_position,
  output logic [7:0] data_byte,
  output logic       frame_good,
  output logic       frame_overflow,
  // frame type register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] frame_type;

  // skid stage behind the output register
  logic             skid_valid;
  afr_pkg::result_t skid;
  afr_pkg::result_t result;
  afr_pkg::result_t out_reg;

  logic accept;
  logic out_free;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // config write, taken at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type <= afr_pkg::RESET_FRAME_TYPE;
    end else if (cfg_valid && cfg_ready) begin
      frame_type <= cfg_data;
    end
  end

  // per-byte parser with its own frame state
  afr_parser #(
    .MAX_FRAME_DATA(MAX_FRAME_DATA)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .frame_type(frame_type),
    .result    (result)
  );

  // output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no beat is taken while it is full
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

  assign out_kind       = out_reg.kind;
  assign data_position  = out_reg.position;
  assign data_byte      = out_reg.data;
  assign frame_good     = out_reg.good;
  assign frame_overflow = out_reg.overflow;

  // skid only fills behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  // a held result with a full skid stays in place
  a_hold_with_skid : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && skid_valid) |=> (out_valid && skid_valid))
    else $error("beat lost while output stalled");

  // end flags only on frame end and never both
  a_flags_on_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_good || frame_overflow)) |->
      (out_kind == afr_pkg::KIND_END && !(frame_good && frame_overflow)))
    else $error("frame flags set outside frame end");

  // position only carried by data beats
  a_position_on_data : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != afr_pkg::KIND_DATA) |-> (data_position == 6'd0))
    else $error("data position set on non-data beat");

endmodule

// File: rtl/afr_parser.sv
module afr_parser #(
  parameter int MAX_FRAME_DATA = afr_pkg::MAX_FRAME_DATA_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       frame_type,
  output afr_pkg::result_t result
);

  localparam int CountW = $clog2(MAX_FRAME_DATA + 1);

  afr_pkg::phase_t phase, phase_next;
  logic              len_seen, len_seen_next;
  logic [15:0]       remaining, remaining_next;
  logic [CountW-1:0] data_count, data_count_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        first_byte, first_byte_next;

  logic [15:0] full_len;
  logic [15:0] rem_dec;

  assign full_len = {remaining[15:8], rx_byte};
  assign rem_dec  = remaining - 16'd1;

  always_comb begin
    phase_next       = phase;
    len_seen_next    = len_seen;
    remaining_next   = remaining;
    data_count_next  = data_count;
    running_sum_next = running_sum;
    first_byte_next  = first_byte;
    result.kind      = afr_pkg::KIND_DISCARD;
    result.position  = 6'd0;
    result.data      = rx_byte;
    result.good      = 1'b0;
    result.overflow  = 1'b0;
    if (rx_byte == afr_pkg::START_BYTE) begin
      // resync on any start byte, frame in progress is dropped
      phase_next       = afr_pkg::PH_LEN;
      len_seen_next    = 1'b0;
      remaining_next   = 16'd0;
      data_count_next  = '0;
      running_sum_next = 8'd0;
      first_byte_next  = 8'd0;
    end else begin
      case (phase)
        afr_pkg::PH_LEN: begin
          result.kind = afr_pkg::KIND_LEN;
          if (!len_seen) begin
            remaining_next = {rx_byte, 8'h00};
            len_seen_next  = 1'b1;
          end else begin
            remaining_next = full_len;
            len_seen_next  = 1'b0;
            phase_next     = (full_len == 16'd0) ? afr_pkg::PH_CSUM : afr_pkg::PH_DATA;
          end
        end
        afr_pkg::PH_DATA: begin
          if (data_count >= CountW'(MAX_FRAME_DATA)) begin
            phase_next      = afr_pkg::PH_HUNT;
            result.kind     = afr_pkg::KIND_END;
            result.overflow = 1'b1;
          end else begin
            if (data_count == '0) begin
              first_byte_next = rx_byte;
            end
            running_sum_next = running_sum + rx_byte;
            result.kind      = afr_pkg::KIND_DATA;
            result.position  = 6'(data_count);
            data_count_next  = data_count + CountW'(1);
            remaining_next   = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_next = afr_pkg::PH_CSUM;
            end
          end
        end
        afr_pkg::PH_CSUM: begin
          phase_next  = afr_pkg::PH_HUNT;
          result.kind = afr_pkg::KIND_END;
          result.good = (first_byte == frame_type) &&
                        ((afr_pkg::CSUM_BASE - running_sum) == rx_byte);
        end
        default: begin
          result.kind = afr_pkg::KIND_DISCARD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= afr_pkg::PH_HUNT;
      len_seen    <= 1'b0;
      remaining   <= 16'd0;
      data_count  <= '0;
      running_sum <= 8'd0;
      first_byte  <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      len_seen    <= len_seen_next;
      remaining   <= remaining_next;
      data_count  <= data_count_next;
      running_sum <= running_sum_next;
      first_byte  <= first_byte_next;
    end
  end

endmodule
